// ===== rtl/buddy_tree_partition_select_assert.svh =====
// ----------------------------------------------------------------------------
// Buddy tree partition select: assertion macros
// Shared assertion helpers. Every property is sampled on clk_i and disabled
// while rst_ni is low. Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef BUDDY_TREE_PARTITION_SELECT_ASSERT_SVH
`define BUDDY_TREE_PARTITION_SELECT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BTPS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define BTPS_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);
`else
`define BTPS_ASSERT(name, prop, msg)
`define BTPS_NEVER(name, expr, msg)
`endif
`endif

// ===== rtl/btps_pkg.sv =====
// ----------------------------------------------------------------------------
// Buddy tree partition select: package
// Field widths, beat payload types, opcodes and the controller/datapath
// command and status types.
// ----------------------------------------------------------------------------
`default_nettype none

package btps_pkg;

  // Default number of leaves in the buddy tree.
  localparam int unsigned LeafCountDefault = 32;

  // Payload field widths.
  localparam int unsigned CostW = 32;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned ModeW = 2;

  // Operation codes carried in the mode field.
  typedef enum logic [ModeW-1:0] {
    MODE_WRITE  = 2'd0,
    MODE_REDUCE = 2'd1,
    MODE_READ   = 2'd2
  } mode_e;

  // Input beat.
  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [IdxW-1:0]  node_index;
    logic [CostW-1:0] cost_value;
  } in_item_t;

  // Output beat.
  typedef struct packed {
    logic             node_chosen;
    logic [CostW-1:0] node_cost;
    logic             op_done;
  } out_item_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RED_CHILD,
    ST_RED_PARENT,
    ST_RED_WRITE,
    ST_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic item_load;     // capture the accepted input beat
    logic rd_en;         // read both node memory ports
    logic rd_from_input; // port A address comes from the input beat
    logic b_oob;         // port B child lies outside the tree (cost zero)
    logic sum_load;      // capture the sum of the two children
    logic tree_write;    // write the reduced parent
    logic clear_write;   // write the reset value of one node
    logic finish;        // complete the item and present its result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;      // the output register can take a result
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/btps_ctrl.sv =====
// ----------------------------------------------------------------------------
// Buddy tree partition select: controller
// Sequences the post-reset clearing sweep, item acceptance and the bottom-up
// reduction walk, level by level and sibling pair by sibling pair.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_tree_partition_select_assert.svh"

module btps_ctrl #(
  parameter int unsigned LEAF_COUNT = btps_pkg::LeafCountDefault,
  localparam int unsigned AddrW = $clog2(2 * LEAF_COUNT)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [btps_pkg::ModeW-1:0]    in_mode_i,
  output logic                          in_ready_o,
  output btps_pkg::dp_cmd_t             cmd_o,
  output logic [AddrW-1:0]              addr_a_o,
  output logic [AddrW-1:0]              addr_b_o,
  input  btps_pkg::dp_status_t          stat_i
);
  import btps_pkg::*;

  localparam int unsigned NodeCount = 2 * LEAF_COUNT;
  localparam int unsigned CntW      = AddrW + 1;
  localparam logic [CntW-1:0]  LeafCnt = CntW'(LEAF_COUNT);
  localparam logic [CntW-1:0]  NodeCnt = CntW'(NodeCount);
  localparam logic [CntW-1:0]  OneCnt  = CntW'(1);
  localparam logic [AddrW-1:0] LastClr = AddrW'(NodeCount - 1);

  ctrl_state_e      state_q, state_d;
  logic [CntW-1:0]  lo_q, lo_d;
  logic [CntW-1:0]  hi_q, hi_d;
  logic [CntW-1:0]  i_q, i_d;
  logic [AddrW-1:0] clr_q, clr_d;

  logic [CntW-1:0]  i_next;
  logic [CntW-1:0]  child_b;
  logic [CntW-1:0]  par;
  logic [CntW-1:0]  lo_half;

  // Walk arithmetic: next pair, right sibling, parent and next level start.
  assign i_next  = i_q + CntW'(2);
  assign child_b = i_q + OneCnt;
  assign par     = i_q >> 1;
  assign lo_half = lo_q >> 1;

  // State and counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      lo_q    <= '0;
      hi_q    <= '0;
      i_q     <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      i_q     <= i_d;
      clr_q   <= clr_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    i_d        = i_q;
    clr_d      = clr_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    addr_a_o   = '0;
    addr_b_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_write = 1'b1;
        addr_a_o          = clr_q;
        if (clr_q == LastClr) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AddrW'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o          = 1'b1;
        cmd_o.rd_from_input = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.rd_en     = 1'b1;
          if (in_mode_i == MODE_REDUCE) begin
            lo_d    = LeafCnt;
            hi_d    = NodeCnt;
            i_d     = LeafCnt;
            state_d = ST_RED_CHILD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_RED_CHILD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.b_oob = (child_b >= NodeCnt);
        addr_a_o    = i_q[AddrW-1:0];
        addr_b_o    = child_b[AddrW-1:0];
        state_d     = ST_RED_PARENT;
      end
      ST_RED_PARENT: begin
        cmd_o.sum_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        addr_a_o       = par[AddrW-1:0];
        state_d        = ST_RED_WRITE;
      end
      ST_RED_WRITE: begin
        cmd_o.tree_write = 1'b1;
        addr_a_o         = par[AddrW-1:0];
        if (i_next < hi_q) begin
          i_d     = i_next;
          state_d = ST_RED_CHILD;
        end else begin
          // Level done: move up one level.
          hi_d = lo_q;
          lo_d = lo_half;
          i_d  = lo_half;
          if (lo_half > OneCnt) begin
            state_d = ST_RED_CHILD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Checks on the walk sequencing.
  `BTPS_ASSERT(a_red_start, (in_valid_i && in_ready_o && in_mode_i == MODE_REDUCE) |=> (state_q == ST_RED_CHILD), "reduce beat did not start the walk")
  `BTPS_ASSERT(a_finish_hold, (state_q == ST_FINISH && !stat_i.out_free) |=> (state_q == ST_FINISH), "left finish with the output register full")
  `BTPS_ASSERT(a_child_range, (state_q == ST_RED_CHILD) |-> (i_q >= lo_q && i_q < hi_q), "child index outside its level")

endmodule

`default_nettype wire

// ===== rtl/btps_dp.sv =====
// ----------------------------------------------------------------------------
// Buddy tree partition select: datapath
// Node cost and chosen mark memories, the item register, the child sum and
// parent decision of the reduction, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_tree_partition_select_assert.svh"

module btps_dp #(
  parameter int unsigned LEAF_COUNT = btps_pkg::LeafCountDefault,
  localparam int unsigned AddrW = $clog2(2 * LEAF_COUNT)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  btps_pkg::in_item_t    in_i,
  input  btps_pkg::dp_cmd_t     cmd_i,
  input  logic [AddrW-1:0]      addr_a_i,
  input  logic [AddrW-1:0]      addr_b_i,
  output btps_pkg::dp_status_t  stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output btps_pkg::out_item_t   out_o
);
  import btps_pkg::*;

  localparam int unsigned NodeCount = 2 * LEAF_COUNT;
  localparam int unsigned CmpW = (AddrW + 1 > IdxW) ? AddrW + 1 : IdxW;
  localparam logic [CmpW-1:0]  NodeLim  = CmpW'(NodeCount);
  localparam logic [AddrW-1:0] LeafAddr = AddrW'(LEAF_COUNT);

  // Node storage: cost and chosen mark.
  logic [CostW-1:0] cost_mem_q [NodeCount];
  logic             mark_mem_q [NodeCount];

  in_item_t         item_q;
  logic [CostW-1:0] rd_cost_a_q, rd_cost_b_q;
  logic             rd_mark_a_q;
  logic             b_oob_q;
  logic [CostW:0]   sum_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic [CmpW-1:0]  in_idx_w;
  logic [CmpW-1:0]  item_idx_w;
  logic [AddrW-1:0] rd_addr_a;
  logic [AddrW-1:0] item_addr;
  logic             item_inside;
  logic             item_wr;
  logic             parent_keep;
  logic [CostW-1:0] sum_sat;
  logic [CostW:0]   sum_d;
  logic             cost_we, mark_we;
  logic [AddrW-1:0] wr_addr;
  logic [CostW-1:0] wr_cost;
  logic             wr_mark;
  logic             out_free;
  logic             out_load;
  out_item_t        res;

  // Address forming and range check of the item's node.
  assign in_idx_w    = CmpW'(in_i.node_index);
  assign item_idx_w  = CmpW'(item_q.node_index);
  assign rd_addr_a   = cmd_i.rd_from_input ? in_idx_w[AddrW-1:0] : addr_a_i;
  assign item_addr   = item_idx_w[AddrW-1:0];
  assign item_inside = (item_idx_w < NodeLim);

  // Reduction arithmetic: exact child sum, parent decision, saturation.
  assign sum_d       = {1'b0, rd_cost_a_q} +
                       {1'b0, (b_oob_q ? {CostW{1'b0}} : rd_cost_b_q)};
  assign parent_keep = ({1'b0, rd_cost_a_q} < sum_q);
  assign sum_sat     = sum_q[CostW] ? '1 : sum_q[CostW-1:0];

  // Write port selection.
  assign item_wr = cmd_i.finish && (item_q.mode == MODE_WRITE) && item_inside;
  always_comb begin
    cost_we = item_wr || cmd_i.tree_write || cmd_i.clear_write;
    mark_we = cmd_i.tree_write || cmd_i.clear_write;
    wr_addr = item_wr ? item_addr : addr_a_i;
    wr_cost = '0;
    wr_mark = 1'b0;
    if (cmd_i.clear_write) begin
      wr_mark = (addr_a_i >= LeafAddr);
    end else if (cmd_i.tree_write) begin
      wr_mark = parent_keep;
      wr_cost = parent_keep ? rd_cost_a_q : sum_sat;
    end else begin
      wr_cost = item_q.cost_value;
    end
  end

  // Node memories with registered reads on two ports.
  always_ff @(posedge clk_i) begin
    if (cost_we) begin
      cost_mem_q[wr_addr] <= wr_cost;
    end
    if (mark_we) begin
      mark_mem_q[wr_addr] <= wr_mark;
    end
    if (cmd_i.rd_en) begin
      rd_cost_a_q <= cost_mem_q[rd_addr_a];
      rd_mark_a_q <= mark_mem_q[rd_addr_a];
      rd_cost_b_q <= cost_mem_q[addr_b_i];
      b_oob_q     <= cmd_i.b_oob;
    end
  end

  // Item and child sum registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= in_i;
    end
    if (cmd_i.sum_load) begin
      sum_q <= sum_d;
    end
  end

  // Result of the finished item.
  always_comb begin
    res = '0;
    case (mode_e'(item_q.mode))
      MODE_WRITE: begin
        res.node_cost = item_inside ? item_q.cost_value : '0;
        res.op_done   = 1'b1;
      end
      MODE_REDUCE: begin
        res.op_done = 1'b1;
      end
      MODE_READ: begin
        res.node_chosen = item_inside && rd_mark_a_q;
        res.node_cost   = item_inside ? rd_cost_a_q : '0;
        res.op_done     = 1'b1;
      end
      default: begin
        res = '0;
      end
    endcase
  end

  // Output register.
  assign out_free        = !out_valid_q || out_ready_i;
  assign out_load        = cmd_i.finish && out_free;
  assign stat_o.out_free = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks on the datapath sequencing.
  `BTPS_ASSERT(a_out_from_finish, $rose(out_valid_q) |-> $past(cmd_i.finish), "result appeared without a finish")
  `BTPS_ASSERT(a_finish_loads, (cmd_i.finish && out_free) |=> out_valid_q, "finish with free output did not load a result")
  `BTPS_ASSERT(a_sum_before_write, cmd_i.tree_write |-> $past(cmd_i.sum_load), "parent written without a fresh child sum")

endmodule

`default_nettype wire

// ===== rtl/buddy_tree_partition_select.sv =====
// Write, read and no-op beats: accepted in ST_IDLE; ST_FINISH then registers the result once the
// output register is free, and the next beat is taken only after ST_FINISH; the output register
// lets the next beat in while a result waits. Reduce beat: each sibling pair passes through
// ST_RED_CHILD, ST_RED_PARENT and ST_RED_WRITE on the two-port node memory, then ST_FINISH.
// After reset a clearing sweep writes all 2 * LEAF_COUNT nodes, one per cycle, with ready low.
// ----------------------------------------------------------------------------
// Buddy tree partition select: top level
// Keeps a buddy tree of node logging costs, reduces it bottom-up to pick the
// cheapest granularity, and serves node writes and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_tree_partition_select #(
  parameter int unsigned LEAF_COUNT = btps_pkg::LeafCountDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btps_pkg::in_item_t   in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btps_pkg::out_item_t  out_o
);
  import btps_pkg::*;

  localparam int unsigned AddrW = $clog2(2 * LEAF_COUNT);

  dp_cmd_t          cmd;
  dp_status_t       stat;
  logic [AddrW-1:0] addr_a;
  logic [AddrW-1:0] addr_b;

  // Sequencer.
  btps_ctrl #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_i.mode),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .addr_a_o   (addr_a),
    .addr_b_o   (addr_b),
    .stat_i     (stat)
  );

  // Node storage and arithmetic.
  btps_dp #(
    .LEAF_COUNT (LEAF_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .addr_a_i    (addr_a),
    .addr_b_i    (addr_b),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_buddy_tree_partition_select.sv =====
// ----------------------------------------------------------------------------
// Buddy tree partition select: testbench
// Drives node write, reduce and read beats through the valid/ready input
// channel and mirrors the buddy tree state so that each output beat can be
// predicted. Every output beat is compared field by field with the oldest
// prediction. A directed part covers the field extremes, node zero, both
// outcomes of the reduction and the unused mode. A random part follows,
// built mostly of write bursts, a reduce and read-back, with noise mixed in.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_buddy_tree_partition_select;
  import btps_pkg::*;

  localparam int unsigned LEAVES      = LeafCountDefault;
  localparam int unsigned NODES       = 2 * LEAVES;
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned RANDOM_BEATS = 1550;
  localparam int unsigned DRAIN_CYCLES = 3 * LEAVES + 40;
  localparam int unsigned CYCLE_LIMIT  = 300000;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;

  // Mirror of the tree and the queue of answers still owed by the block.
  logic [CostW-1:0] cost_mem [NODES];
  logic             chosen_mem [NODES];
  out_item_t        answer_q [$];

  int unsigned beats_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned hold_cycles    = 0;
  bit          idle_on        = 1'b1;

  buddy_tree_partition_select #(
    .LEAF_COUNT(LEAVES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d answers outstanding", CYCLE_LIMIT,
             answer_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // Bottom-up walk: a parent cheaper than its children is kept, otherwise it
  // takes the saturated sum of the two children.
  function automatic void reduce_tree();
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    int unsigned par;
    logic [CostW:0] left;
    logic [CostW:0] right;
    logic [CostW:0] sum;
    lo = LEAVES;
    hi = NODES;
    while (lo > 1) begin
      for (i = lo; i < hi; i += 2) begin
        par   = i / 2;
        left  = (i < NODES) ? {1'b0, cost_mem[i]} : '0;
        right = (i + 1 < NODES) ? {1'b0, cost_mem[i + 1]} : '0;
        sum   = left + right;
        if ({1'b0, cost_mem[par]} < sum) begin
          chosen_mem[par] = 1'b1;
        end else begin
          chosen_mem[par] = 1'b0;
          cost_mem[par]   = sum[CostW] ? '1 : sum[CostW-1:0];
        end
      end
      hi = lo;
      lo = lo / 2;
    end
  endfunction

  // Apply one accepted beat to the mirror and return the answer it causes.
  function automatic out_item_t predict_answer(input in_item_t b);
    out_item_t ans;
    bit        in_tree;
    ans     = '0;
    in_tree = (int'(b.node_index) < NODES);
    case (b.mode)
      MODE_WRITE: begin
        if (in_tree) begin
          cost_mem[b.node_index] = b.cost_value;
          ans.node_cost          = b.cost_value;
        end
        ans.op_done = 1'b1;
      end
      MODE_REDUCE: begin
        reduce_tree();
        ans.op_done = 1'b1;
      end
      MODE_READ: begin
        if (in_tree) begin
          ans.node_chosen = chosen_mem[b.node_index];
          ans.node_cost   = cost_mem[b.node_index];
        end
        ans.op_done = 1'b1;
      end
      default: begin
        ans = '0;
      end
    endcase
    return ans;
  endfunction

  // Send one beat after a random gap; predict its answer once accepted.
  task automatic send_beat(input logic [ModeW-1:0] mode, input int unsigned idx,
                           input logic [CostW-1:0] cost);
    in_item_t    b;
    int unsigned gap;
    b.mode       = mode;
    b.node_index = idx[IdxW-1:0];
    b.cost_value = cost;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= b;
    do @(posedge clk_i); while (!in_ready_o);
    answer_q.push_back(predict_answer(b));
    beats_sent++;
  endtask

  // Receiver: stalls a random number of cycles after each beat and checks it.
  always @(posedge clk_i) begin : check_answers
    out_item_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cycles = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (answer_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected output beat: chosen %0b cost %h done %0b",
                     out_o.node_chosen, out_o.node_cost, out_o.op_done);
          end
        end else begin
          want = answer_q.pop_front();
          if (out_o.node_chosen !== want.node_chosen ||
              out_o.node_cost !== want.node_cost ||
              out_o.op_done !== want.op_done) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("mismatch: expected chosen %0b cost %h done %0b,",
                       want.node_chosen, want.node_cost, want.op_done,
                       " got chosen %0b cost %h done %0b",
                       out_o.node_chosen, out_o.node_cost, out_o.op_done);
            end
          end
        end
        hold_cycles = idle_on ? $urandom_range(0, 7) : 0;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      out_ready_i <= (hold_cycles == 0);
    end
  end

  // Random cost with weight on zero, the maximum and the edges near them.
  function automatic logic [CostW-1:0] pick_cost();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CostW'($urandom_range(0, 255));
      3:       return '1 - CostW'($urandom_range(0, 255));
      default: return $urandom;
    endcase
  endfunction

  // Reset contents: leaves chosen, inner nodes and node zero unchosen.
  task automatic test_reset_values();
    send_beat(MODE_READ, 0, '0);
    send_beat(MODE_READ, 1, '1);
    send_beat(MODE_READ, LEAVES - 1, '0);
    send_beat(MODE_READ, LEAVES, '0);
    send_beat(MODE_READ, NODES - 1, '1);
  endtask

  // Field extremes and node zero as plain storage.
  task automatic test_write_read_extremes();
    send_beat(MODE_WRITE, NODES - 1, '1);
    send_beat(MODE_READ, NODES - 1, '0);
    send_beat(MODE_WRITE, LEAVES, '0);
    send_beat(MODE_READ, LEAVES, '1);
    send_beat(MODE_WRITE, 0, '1);
    send_beat(MODE_READ, 0, '0);
    send_beat(MODE_WRITE, 45, 32'h5555_5555);
    send_beat(MODE_READ, 45, '0);
    send_beat(MODE_WRITE, 46, 32'hAAAA_AAAA);
    send_beat(MODE_READ, 46, '0);
  endtask

  // One parent kept over its children, one replaced by their sum.
  task automatic test_reduce_outcomes();
    send_beat(MODE_WRITE, 17, 32'd1);
    send_beat(MODE_WRITE, 34, 32'd5);
    send_beat(MODE_WRITE, 35, 32'd5);
    send_beat(MODE_WRITE, 18, '1);
    send_beat(MODE_WRITE, 36, 32'd1);
    send_beat(MODE_WRITE, 37, 32'd2);
    send_beat(MODE_REDUCE, 0, '0);
    send_beat(MODE_READ, 17, '0);
    send_beat(MODE_READ, 18, '0);
    send_beat(MODE_READ, 1, '0);
  endtask

  // The unused mode answers all zero.
  task automatic test_unused_mode();
    send_beat(MODE_UNUSED, NODES - 1, '1);
  endtask

  // Mostly write bursts followed by a reduce and read-back, plus noise.
  task automatic test_random_traffic();
    int unsigned goal;
    int unsigned n;
    int unsigned k;
    int unsigned idx;
    goal = beats_sent + RANDOM_BEATS;
    while (beats_sent < goal) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        n = $urandom_range(4, 40);
        for (k = 0; k < n; k++) begin
          idx = ($urandom_range(0, 9) < 7) ? $urandom_range(LEAVES, NODES - 1)
                                           : $urandom_range(1, LEAVES - 1);
          send_beat(MODE_WRITE, idx, pick_cost());
        end
        send_beat(MODE_REDUCE, $urandom_range(0, NODES - 1), $urandom);
        n = $urandom_range(2, 12);
        for (k = 0; k < n; k++) begin
          idx = ($urandom_range(0, 3) != 0) ? $urandom_range(1, LEAVES - 1)
                                            : $urandom_range(0, NODES - 1);
          send_beat(MODE_READ, idx, $urandom);
        end
      end else begin
        n = $urandom_range(1, 20);
        for (k = 0; k < n; k++) begin
          case ($urandom_range(0, 19))
            0:       send_beat(MODE_UNUSED, $urandom_range(0, NODES - 1), $urandom);
            1:       send_beat(MODE_REDUCE, $urandom_range(0, NODES - 1), $urandom);
            2, 3, 4, 5, 6, 7, 8, 9:
                     send_beat(MODE_WRITE, $urandom_range(0, NODES - 1), pick_cost());
            default: send_beat(MODE_READ, $urandom_range(0, NODES - 1), $urandom);
          endcase
        end
      end
    end
  endtask

  // Main sequence.
  initial begin
    for (int i = 0; i < NODES; i++) begin
      cost_mem[i]   = '0;
      chosen_mem[i] = (i >= LEAVES);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_write_read_extremes();
    test_reduce_outcomes();
    test_unused_mode();
    test_random_traffic();

    in_valid_i <= 1'b0;
    idle_on = 1'b1;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/btps_pkg.sv
rtl/btps_ctrl.sv
rtl/btps_dp.sv
rtl/buddy_tree_partition_select.sv
tb/tb_buddy_tree_partition_select.sv
